// ----- design/fcca_pkg.sv -----
// ----------------------------------------------------------------------------
// fcca_pkg
// Shared types, codes and constants of the cluster chain allocator.
// ----------------------------------------------------------------------------
package fcca_pkg;

    // Default configuration of the table.
    localparam int TABLE_DEPTH_DEF        = 512;
    localparam int CLUSTER_BYTES_DEF      = 2048;
    localparam int FIRST_FREE_CLUSTER_DEF = 3;

    // Table words.
    localparam logic [31:0] FAT_END       = 32'h0FFF_FFFF;
    localparam logic [31:0] FAT_EMPTY     = 32'h0000_0000;
    localparam logic [31:0] CLUSTER0_WORD = 32'h0FFF_FFF0;
    localparam logic [31:0] CLUSTER1_WORD = 32'h0FFF_FFFF;

    // Command codes.
    localparam logic [1:0] CMD_ALLOC = 2'd0;
    localparam logic [1:0] CMD_FREE  = 2'd1;
    localparam logic [1:0] CMD_LEN   = 2'd2;
    localparam logic [1:0] CMD_READ  = 2'd3;

    // Status codes.
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NO_SPACE = 2'd1;
    localparam logic [1:0] ST_PARTIAL  = 2'd2;
    localparam logic [1:0] ST_BAD      = 2'd3;

    typedef struct packed {
        logic [1:0]  command;
        logic [31:0] byte_length;
        logic [8:0]  start_cluster;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  status;
        logic [8:0]  first_cluster;
        logic [9:0]  num_clusters;
        logic [31:0] entry_value;
    } t_out_item;

endpackage

// ----- design/fcca_table.sv -----
// ----------------------------------------------------------------------------
// fcca_table
// Cluster link memory: one write port, one registered read port with
// write-to-read bypass, and an initialization sweep after reset.
// ----------------------------------------------------------------------------
module fcca_table #(
    parameter int TABLE_DEPTH = fcca_pkg::TABLE_DEPTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_wr_en,
    input  logic [$clog2(TABLE_DEPTH)-1:0] i_wr_addr,
    input  logic [31:0]                    i_wr_data,
    input  logic                           i_rd_en,
    input  logic [$clog2(TABLE_DEPTH)-1:0] i_rd_addr,
    output logic [31:0]                    o_rd_data,
    output logic                           o_ready
);
    import fcca_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);

    logic [31:0]   r_mem [TABLE_DEPTH];
    logic [31:0]   r_q;
    logic          r_byp;
    logic [31:0]   r_byp_data;
    logic          r_busy;
    logic [AW-1:0] r_init_addr;

    logic          w_we;
    logic [AW-1:0] w_wa;
    logic [31:0]   w_wd;

    function automatic logic [31:0] init_word(input logic [AW-1:0] addr);
        logic [31:0] word;
        word = FAT_EMPTY;
        if (addr == AW'(0)) begin
            word = CLUSTER0_WORD;
        end else if (addr == AW'(1)) begin
            word = CLUSTER1_WORD;
        end else if (addr == AW'(2)) begin
            word = FAT_END;
        end
        return word;
    endfunction

    // Sweep the reset image into the array, one entry a cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b1;
            r_init_addr <= '0;
        end else if (r_busy) begin
            r_init_addr <= r_init_addr + 1'b1;
            if (r_init_addr == AW'(TABLE_DEPTH - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_comb begin
        w_we = r_busy | i_wr_en;
        w_wa = r_busy ? r_init_addr : i_wr_addr;
        w_wd = r_busy ? init_word(r_init_addr) : i_wr_data;
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_wa] <= w_wd;
        end
        if (i_rd_en) begin
            r_q        <= r_mem[i_rd_addr];
            r_byp      <= i_wr_en && (i_wr_addr == i_rd_addr);
            r_byp_data <= i_wr_data;
        end
    end

    assign o_rd_data = r_byp ? r_byp_data : r_q;
    assign o_ready   = !r_busy;

endmodule

// ----- design/fat_cluster_chain_allocator.sv -----
// ----------------------------------------------------------------------------
// fat_cluster_chain_allocator
// File allocation table of cluster links with allocate, free, length and
// read commands. One transaction in, one result transaction out. The table
// lives in a single memory with one read and one write port, and every
// command is served one entry per cycle through that read port: allocate
// scans from FIRST_FREE_CLUSTER upward, at most to the end of the table, a
// free or length walk takes one chain member at a time plus setup and
// delivery, and a read fetches a single entry. Commands run one at a time;
// the next transaction is taken as soon as the previous result sits in the
// output register, even while that result is stalled. After reset the table
// is loaded with its initial image, during which the input stays stalled.
// ----------------------------------------------------------------------------
module fat_cluster_chain_allocator #(
    parameter int TABLE_DEPTH        = fcca_pkg::TABLE_DEPTH_DEF,
    parameter int CLUSTER_BYTES      = fcca_pkg::CLUSTER_BYTES_DEF,
    parameter int FIRST_FREE_CLUSTER = fcca_pkg::FIRST_FREE_CLUSTER_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  fcca_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output fcca_pkg::t_out_item o_out_data
);
    import fcca_pkg::*;

    // Address width, count width (holds TABLE_DEPTH itself) and the width of
    // the scan pointer, which must hold both the first free cluster and the
    // depth.
    localparam int AW   = $clog2(TABLE_DEPTH);
    localparam int CW   = $clog2(TABLE_DEPTH + 1);
    localparam int KMAX = (TABLE_DEPTH > FIRST_FREE_CLUSTER) ? TABLE_DEPTH
                                                             : FIRST_FREE_CLUSTER;
    localparam int KW   = $clog2(KMAX + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ALLOC,
        S_ALLOC_END,
        S_WALK_START,
        S_WALK,
        S_RD_ISSUE,
        S_RD_DATA,
        S_DONE
    } t_state;

    t_state        r_state,     n_state;
    logic          r_clear,     n_clear;     // free walk clears, length walk counts
    logic [KW-1:0] r_k,         n_k;         // next scan address to issue
    logic          r_dv,        n_dv;        // read data of the scan is valid
    logic [AW-1:0] r_daddr,     n_daddr;     // address of that read data
    logic [31:0]   r_remain,    n_remain;    // bytes still to be covered
    logic [CW-1:0] r_got,       n_got;       // clusters taken, freed or counted
    logic [AW-1:0] r_first,     n_first;
    logic [AW-1:0] r_prev,      n_prev;      // last cluster taken
    logic [31:0]   r_cur,       n_cur;       // current chain member / read index
    t_out_item     r_res,       n_res;
    logic          r_out_valid, n_out_valid;
    t_out_item     r_out,       n_out;

    logic          w_accept;
    logic          w_tbl_ready;
    logic          w_wr_en;
    logic [AW-1:0] w_wr_addr;
    logic [31:0]   w_wr_data;
    logic          w_rd_en;
    logic [AW-1:0] w_rd_addr;
    logic [31:0]   w_rd_data;
    logic          w_take;
    logic [CW-1:0] w_cnt1;

    fcca_table #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data),
        .o_ready   (w_tbl_ready)
    );

    // Take a new command only when idle and the table image is loaded.
    assign o_in_stall  = !((r_state == S_IDLE) && w_tbl_ready);
    assign w_accept    = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // A scanned entry is taken when its data is back and reads free.
    assign w_take = r_dv && (w_rd_data == FAT_EMPTY);
    assign w_cnt1 = r_got + 1'b1;

    always_comb begin
        n_state     = r_state;
        n_clear     = r_clear;
        n_k         = r_k;
        n_dv        = r_dv;
        n_daddr     = r_daddr;
        n_remain    = r_remain;
        n_got       = r_got;
        n_first     = r_first;
        n_prev      = r_prev;
        n_cur       = r_cur;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        w_wr_en     = 1'b0;
        w_wr_addr   = '0;
        w_wr_data   = FAT_EMPTY;
        w_rd_en     = 1'b0;
        w_rd_addr   = '0;

        // Drop the held result once the consumer takes it.
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_res   = '0;
                    n_got   = '0;
                    n_first = '0;
                    n_cur   = 32'(i_in_data.start_cluster);
                    n_clear = (i_in_data.command == CMD_FREE);
                    unique case (i_in_data.command) inside
                        CMD_ALLOC: begin
                            n_k      = KW'(FIRST_FREE_CLUSTER);
                            n_dv     = 1'b0;
                            // A zero length still asks for one cluster.
                            n_remain = (i_in_data.byte_length == 32'd0) ? 32'd1
                                                                       : i_in_data.byte_length;
                            n_state  = S_ALLOC;
                        end
                        CMD_FREE, CMD_LEN: begin
                            n_state = S_WALK_START;
                        end
                        CMD_READ: begin
                            n_state = S_RD_ISSUE;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end

            S_ALLOC: begin
                // Issue one scan read per cycle; its data comes back through the registered read port.
                if (r_k < KW'(TABLE_DEPTH)) begin
                    w_rd_en   = 1'b1;
                    w_rd_addr = r_k[AW-1:0];
                    n_k       = r_k + 1'b1;
                    n_dv      = 1'b1;
                    n_daddr   = r_k[AW-1:0];
                end else begin
                    n_dv = 1'b0;
                end

                if (w_take) begin
                    // Link the previous cluster to this one.
                    if (r_got == '0) begin
                        n_first = r_daddr;
                    end else begin
                        w_wr_en   = 1'b1;
                        w_wr_addr = r_prev;
                        w_wr_data = 32'(r_daddr);
                    end
                    n_prev   = r_daddr;
                    n_got    = w_cnt1;
                    n_remain = (r_remain <= 32'(CLUSTER_BYTES))
                             ? 32'd0 : (r_remain - 32'(CLUSTER_BYTES));
                    if (r_remain <= 32'(CLUSTER_BYTES)) begin
                        n_state = S_ALLOC_END;
                    end
                end else if (!r_dv && (r_k >= KW'(TABLE_DEPTH))) begin
                    // Table exhausted.
                    if (r_got == '0) begin
                        n_res.status = ST_NO_SPACE;
                        n_state      = S_DONE;
                    end else begin
                        n_state = S_ALLOC_END;
                    end
                end
            end

            S_ALLOC_END: begin
                // Terminate the new chain.
                w_wr_en             = 1'b1;
                w_wr_addr           = r_prev;
                w_wr_data           = FAT_END;
                n_res.status        = (r_remain != 32'd0) ? ST_PARTIAL : ST_OK;
                n_res.first_cluster = 9'(r_first);
                n_res.num_clusters  = 10'(r_got);
                n_state             = S_DONE;
            end

            S_WALK_START: begin
                if ((r_cur >= 32'd2) && (r_cur < 32'(TABLE_DEPTH))) begin
                    w_rd_en   = 1'b1;
                    w_rd_addr = r_cur[AW-1:0];
                    n_state   = S_WALK;
                end else begin
                    n_res.status = ST_BAD;
                    n_state      = S_DONE;
                end
            end

            S_WALK: begin
                if (w_rd_data == FAT_EMPTY) begin
                    n_res.status       = ST_BAD;
                    n_res.num_clusters = 10'(r_got);
                    n_state            = S_DONE;
                end else begin
                    // Clear the member on a free; a read of the same entry in
                    // this cycle sees the cleared word through the bypass.
                    if (r_clear) begin
                        w_wr_en   = 1'b1;
                        w_wr_addr = r_cur[AW-1:0];
                        w_wr_data = FAT_EMPTY;
                    end
                    n_got              = w_cnt1;
                    n_res.num_clusters = 10'(w_cnt1);
                    if (w_rd_data == FAT_END) begin
                        n_res.status = ST_OK;
                        n_state      = S_DONE;
                    end else if (w_cnt1 >= CW'(TABLE_DEPTH)) begin
                        n_res.status = ST_BAD;
                        n_state      = S_DONE;
                    end else if ((w_rd_data >= 32'd2) && (w_rd_data < 32'(TABLE_DEPTH))) begin
                        w_rd_en   = 1'b1;
                        w_rd_addr = w_rd_data[AW-1:0];
                        n_cur     = w_rd_data;
                    end else begin
                        n_res.status = ST_BAD;
                        n_state      = S_DONE;
                    end
                end
            end

            S_RD_ISSUE: begin
                if (r_cur < 32'(TABLE_DEPTH)) begin
                    w_rd_en   = 1'b1;
                    w_rd_addr = r_cur[AW-1:0];
                    n_state   = S_RD_DATA;
                end else begin
                    n_res.status = ST_BAD;
                    n_state      = S_DONE;
                end
            end

            S_RD_DATA: begin
                n_res.status      = ST_OK;
                n_res.entry_value = w_rd_data;
                n_state           = S_DONE;
            end

            S_DONE: begin
                // Hand the result to the output register once it is free.
                if (!r_out_valid || !i_out_stall) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_dv        <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_dv        <= n_dv;
        end
        r_clear  <= n_clear;
        r_k      <= n_k;
        r_daddr  <= n_daddr;
        r_remain <= n_remain;
        r_got    <= n_got;
        r_first  <= n_first;
        r_prev   <= n_prev;
        r_cur    <= n_cur;
        r_res    <= n_res;
        r_out    <= n_out;
    end

`ifndef SYNTHESIS
    // No command may start while the table image is still being loaded.
    a_no_accept_in_init: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_tbl_ready |-> o_in_stall)
        else $error("transaction accepted during table initialization");

    // A finished result waits while the output register still holds a stalled one.
    a_done_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_out_valid && i_out_stall) |=> (r_state == S_DONE))
        else $error("pending result overwritten");

    // A no-space result carries neither a first cluster nor a count.
    a_no_space_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.status == ST_NO_SPACE)
            |-> (r_out.first_cluster == 9'd0 && r_out.num_clusters == 10'd0))
        else $error("no_space result with nonzero fields");

    // Allocation links only to entries below the scan pointer.
    a_link_behind_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ALLOC && w_wr_en) |-> (KW'(w_wr_addr) < r_k))
        else $error("allocation write ahead of the scan");
`endif

endmodule
